FILE: rtl/core/aaf_pkg.sv
// Package: types, operation codes and flag helpers for the accumulator ALU.
package aaf_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBB   = 5'd3,
        OP_ANA   = 5'd4,
        OP_XRA   = 5'd5,
        OP_ORA   = 5'd6,
        OP_CMP   = 5'd7,
        OP_INR   = 5'd8,
        OP_DCR   = 5'd9,
        OP_RLC   = 5'd10,
        OP_RRC   = 5'd11,
        OP_RAL   = 5'd12,
        OP_RAR   = 5'd13,
        OP_DAA   = 5'd14,
        OP_CMA   = 5'd15,
        OP_STC   = 5'd16,
        OP_CMC   = 5'd17,
        OP_DAD   = 5'd18,
        OP_LDF   = 5'd19,
        OP_TEST  = 5'd20
    } op_t;

    // Condition groups, selected by cond_code[2:1]
    localparam logic [1:0] CC_ZERO   = 2'd0;
    localparam logic [1:0] CC_CARRY  = 2'd1;
    localparam logic [1:0] CC_PARITY = 2'd2;
    localparam logic [1:0] CC_SIGN   = 2'd3;

    typedef struct packed {
        logic [4:0]  op;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  cond_code;
    } in_item_t;

    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  flag_byte;
        logic        cond_met;
    } out_item_t;

    typedef struct packed {
        logic s;
        logic z;
        logic ac;
        logic p;
        logic cy;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{s: 1'b0, z: 1'b1, ac: 1'b0, p: 1'b1, cy: 1'b0};

    // Sign, zero and parity from a byte; aux carry and carry supplied
    function automatic flags_t szp_flags(logic [7:0] r, logic ac, logic cy);
        flags_t f;
        f.s  = r[7];
        f.z  = (r == 8'h00);
        f.ac = ac;
        f.p  = ~^r;
        f.cy = cy;
        return f;
    endfunction

    // S Z 0 AC 0 P 1 CY
    function automatic logic [7:0] pack_flags(flags_t f);
        return {f.s, f.z, 1'b0, f.ac, 1'b0, f.p, 1'b1, f.cy};
    endfunction

endpackage

FILE: rtl/core/accumulator_alu_with_flags_unit.sv
// Top level: accumulator ALU with status flags, one item per cycle while out_ready is not held low.
//
// Usage
//   Input channel (in_valid/in_ready/in_data) carries one operation per item:
//   op, operand_a, operand_b and cond_code. Output channel
//   (out_valid/out_ready/out_data) returns value, the packed flag byte and
//   whether the selected branch condition holds on the updated flags.
//   Items come out in the order they went in, exactly one result per item.
//
// Timing
//   An accepted item sits in the input register while the ALU and flag
//   logic work on it; the result register loads from that logic when it is
//   empty or being drained, and offers the result. Throughput is one item per
//   cycle while out_ready is not held low; the flags register updates as each
//   item moves on, feeding the next item's carry and condition test.
//
// Reset and stalls
//   rst_n clears both valid bits and loads the flags with Z and P set.
//   When the receiver holds out_ready low the result holds, the input
//   register keeps its item, and in_ready drops once both are full.
module accumulator_alu_with_flags_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aaf_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aaf_pkg::out_item_t out_data
);
    import aaf_pkg::*;

    // Input register stage
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    // Result register stage
    logic      out_valid_reg;
    out_item_t out_item_reg;
    // Architectural flags
    flags_t    flags_reg;
    flags_t    flags_next;

    logic      s1_advance;
    out_item_t result_next;

    logic [7:0] a8;
    logic [7:0] b8;
    logic       cy;
    logic [7:0] add_y;
    logic       add_cin;
    logic [8:0] add_sum;
    logic       add_ac;
    logic [7:0] daa_adj;
    logic       daa_setc;
    logic [7:0] inr_val;
    logic [7:0] dcr_val;
    logic [16:0] pair_sum;
    logic [7:0] ldf_bits;
    logic       cond_t;

    // Result register can take a new value when empty or being drained
    assign s1_advance = ~out_valid_reg | out_ready;
    assign in_ready   = ~s1_valid_reg | s1_advance;

    assign a8 = s1_item_reg.operand_a[7:0];
    assign b8 = s1_item_reg.operand_b[7:0];
    assign cy = flags_reg.cy;

    // Decimal adjust correction
    always_comb
    begin
        daa_adj  = 8'h00;
        daa_setc = 1'b0;
        if ((a8[3:0] > 4'd9) || flags_reg.ac)
        begin
            daa_adj = 8'h06;
        end
        if ((a8 > 8'h99) || cy)
        begin
            daa_adj  = daa_adj | 8'h60;
            daa_setc = 1'b1;
        end
    end

    // One shared 8-bit adder for add, subtract, compare and decimal adjust
    always_comb
    begin
        add_y   = b8;
        add_cin = 1'b0;
        case (op_t'(s1_item_reg.op))
            OP_ADC:
            begin
                add_cin = cy;
            end
            OP_SUB, OP_CMP:
            begin
                add_y   = ~b8;
                add_cin = 1'b1;
            end
            OP_SBB:
            begin
                add_y   = ~b8;
                add_cin = ~cy;
            end
            OP_DAA:
            begin
                add_y = daa_adj;
            end
            default:
            begin
                add_y   = b8;
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum  = {1'b0, a8} + {1'b0, add_y} + {8'h00, add_cin};
    assign add_ac   = a8[4] ^ add_y[4] ^ add_sum[4];
    assign inr_val  = a8 + 8'h01;
    assign dcr_val  = a8 + 8'hFF;
    assign pair_sum = {1'b0, s1_item_reg.operand_a} + {1'b0, s1_item_reg.operand_b};
    assign ldf_bits = b8;

    // Operation decode: value and updated flags
    always_comb
    begin
        flags_next        = flags_reg;
        result_next.value = 16'h0000;
        case (op_t'(s1_item_reg.op))
            OP_ADD, OP_ADC:
            begin
                result_next.value = {8'h00, add_sum[7:0]};
                flags_next        = szp_flags(add_sum[7:0], add_ac, add_sum[8]);
            end
            OP_SUB, OP_SBB:
            begin
                result_next.value = {8'h00, add_sum[7:0]};
                flags_next        = szp_flags(add_sum[7:0], add_ac, ~add_sum[8]);
            end
            OP_CMP:
            begin
                result_next.value = s1_item_reg.operand_a;
                flags_next        = szp_flags(add_sum[7:0], add_ac, ~add_sum[8]);
            end
            OP_ANA:
            begin
                result_next.value = {8'h00, a8 & b8};
                flags_next        = szp_flags(a8 & b8, a8[3] | b8[3], 1'b0);
            end
            OP_XRA:
            begin
                result_next.value = {8'h00, a8 ^ b8};
                flags_next        = szp_flags(a8 ^ b8, 1'b0, 1'b0);
            end
            OP_ORA:
            begin
                result_next.value = {8'h00, a8 | b8};
                flags_next        = szp_flags(a8 | b8, 1'b0, 1'b0);
            end
            OP_INR:
            begin
                result_next.value = {8'h00, inr_val};
                flags_next        = szp_flags(inr_val, inr_val[3:0] == 4'h0, cy);
            end
            OP_DCR:
            begin
                result_next.value = {8'h00, dcr_val};
                flags_next        = szp_flags(dcr_val, dcr_val[3:0] != 4'hF, cy);
            end
            OP_RLC:
            begin
                result_next.value = {8'h00, a8[6:0], a8[7]};
                flags_next.cy     = a8[7];
            end
            OP_RRC:
            begin
                result_next.value = {8'h00, a8[0], a8[7:1]};
                flags_next.cy     = a8[0];
            end
            OP_RAL:
            begin
                result_next.value = {8'h00, a8[6:0], cy};
                flags_next.cy     = a8[7];
            end
            OP_RAR:
            begin
                result_next.value = {8'h00, cy, a8[7:1]};
                flags_next.cy     = a8[0];
            end
            OP_DAA:
            begin
                result_next.value = {8'h00, add_sum[7:0]};
                flags_next        = szp_flags(add_sum[7:0], add_ac, daa_setc);
            end
            OP_CMA:
            begin
                result_next.value = {8'h00, ~a8};
            end
            OP_STC:
            begin
                result_next.value = {8'h00, a8};
                flags_next.cy     = 1'b1;
            end
            OP_CMC:
            begin
                result_next.value = {8'h00, a8};
                flags_next.cy     = ~cy;
            end
            OP_DAD:
            begin
                result_next.value = pair_sum[15:0];
                flags_next.cy     = pair_sum[16];
            end
            OP_LDF:
            begin
                flags_next.s      = ldf_bits[7];
                flags_next.z      = ldf_bits[6];
                flags_next.ac     = ldf_bits[4];
                flags_next.p      = ldf_bits[2];
                flags_next.cy     = ldf_bits[0];
                result_next.value = {8'h00, pack_flags(flags_next)};
            end
            default:
            begin
                // test condition and unused codes: no change, value zero
                result_next.value = 16'h0000;
            end
        endcase

        result_next.flag_byte = pack_flags(flags_next);

        case (s1_item_reg.cond_code[2:1])
            CC_ZERO:   cond_t = flags_next.z;
            CC_CARRY:  cond_t = flags_next.cy;
            CC_PARITY: cond_t = flags_next.p;
            CC_SIGN:   cond_t = flags_next.s;
            default:   cond_t = flags_next.z;
        endcase
        result_next.cond_met = s1_item_reg.cond_code[0] ? cond_t : ~cond_t;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= FLAGS_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_advance && s1_valid_reg)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_data;
        end
        if (s1_advance && s1_valid_reg)
        begin
            out_item_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

FILE: rtl/core/aaf_checker.sv
// Checker: port-level properties of the accumulator ALU, bound to the top level.
module aaf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input aaf_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input aaf_pkg::out_item_t out_data
);
    import aaf_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Fixed bits of the packed flag byte
    a_flag_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.flag_byte[1] == 1'b1) && (out_data.flag_byte[3] == 1'b0)
                      && (out_data.flag_byte[5] == 1'b0))
        else $error("flag byte fixed bits wrong");

    // Input is refused only behind a stalled result
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without output stall");

    // An item accepted into an empty unit reaches the output through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid ##1 out_ready |=> out_valid)
        else $error("accepted item did not reach output");

endmodule

bind accumulator_alu_with_flags_unit aaf_checker u_aaf_checker (.*);
